// ===== rtl/core/lbsf_pkg.sv =====
// shared types and constants for the led brightness slew fader
package lbsf_pkg;

    localparam int LEVEL_W = 8;
    localparam int RATE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int ACCUM_W = 9;
    localparam int DT_W    = 8;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_TARGET_LEVEL = 2'd0;
    localparam logic [IDX_W-1:0] REG_RISE_RATE    = 2'd1;
    localparam logic [IDX_W-1:0] REG_FALL_RATE    = 2'd2;

    localparam logic [ACCUM_W-1:0] TICK_MS   = 9'd100;
    localparam logic [ACCUM_W-1:0] ACCUM_MAX = 9'd511;
    localparam logic [RATE_W-1:0]  JUMP_RATE = 8'hff;
    localparam logic [WORD_W-1:0]  WORD_MAX  = 16'hffff;

    typedef struct packed {
        logic [LEVEL_W-1:0] target_level;
        logic [RATE_W-1:0]  rise_rate;
        logic [RATE_W-1:0]  fall_rate;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0]  fade_word;
        logic [ACCUM_W-1:0] time_accum;
    } fader_state_t;

    function automatic logic [WORD_W-1:0] rate_delta(input logic [RATE_W-1:0] rate);
        logic [WORD_W-1:0] r;
        r = {{(WORD_W-RATE_W){1'b0}}, rate};
        // rate * 100 = rate * (64 + 32 + 4)
        return (r << 6) + (r << 5) + (r << 2);
    endfunction

endpackage

// ===== rtl/core/led_brightness_slew_fader_top.sv =====
// led brightness slew fader: tick beat in, level beat out, one per cycle unless stalled
// For each elapsed-time beat the fader returns one result beat: the beat is captured in
// an input register, and the accumulator update, the tick compare and both saturating
// moves of the fade word happen in the single stage that feeds the result register. The
// fade word and accumulator update in that same stage, so consecutive beats see each
// other's effect with no gap. The input side keeps accepting while a result waits,
// until both the input and result registers are full. The user writes registers through
// cfg_we, cfg_index and cfg_wdata only while the block is idle; this is not enforced.
module led_brightness_slew_fader_top
    import lbsf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [RATE_W-1:0]  cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] elapsed_ms
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata    // [0] level_changed, [8:1] level, [9] active
);

    cfg_t              cfg_reg;
    fader_state_t      state_reg;
    fader_state_t      state_next;
    logic              in_valid_reg;
    logic [DT_W-1:0]   in_dt_reg;
    logic              out_valid_reg;
    logic [15:0]       out_data_reg;
    logic              advance;
    logic              changed;
    logic              active;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET_LEVEL: cfg_reg.target_level <= cfg_wdata;
                REG_RISE_RATE:    cfg_reg.rise_rate    <= cfg_wdata;
                REG_FALL_RATE:    cfg_reg.fall_rate    <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    lbsf_step u_step (
        .cfg           (cfg_reg),
        .cur           (state_reg),
        .elapsed_ms    (in_dt_reg),
        .nxt           (state_next),
        .level_changed (changed),
        .active        (active)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_dt_reg <= s_tdata[DT_W-1:0];
        if (advance)
            out_data_reg <= {6'd0, active, state_next.fade_word[WORD_W-1 -: LEVEL_W], changed};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input side stalled with an empty result register");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("fader state moved without a beat");

    a_inactive_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[9] |-> !m_tdata[0])
        else $error("level changed while both rates are zero");

    a_change_level: assert property (@(posedge clk) disable iff (!rst_n)
        advance && changed |=> m_tdata[8:1] != $past(state_reg.fade_word[WORD_W-1 -: LEVEL_W]))
        else $error("change flag set but level unchanged");

endmodule

// ===== rtl/core/lbsf_step.sv =====
// next-state logic of the fader for one tick beat
module lbsf_step
    import lbsf_pkg::*;
(
    input  cfg_t              cfg,
    input  fader_state_t      cur,
    input  logic [DT_W-1:0]   elapsed_ms,
    output fader_state_t      nxt,
    output logic              level_changed,
    output logic              active
);

    logic [ACCUM_W:0]   sum_raw;
    logic [ACCUM_W-1:0] sum_sat;
    logic [WORD_W-1:0]  fall_delta;
    logic [WORD_W-1:0]  rise_delta;
    logic [WORD_W:0]    down_diff;
    logic [WORD_W:0]    up_sum;
    logic [WORD_W-1:0]  word_a;
    logic [WORD_W-1:0]  word_b;
    logic               do_step;

    always_comb
    begin
        active     = (cfg.rise_rate != '0) || (cfg.fall_rate != '0);
        sum_raw    = {1'b0, cur.time_accum} + {{(ACCUM_W+1-DT_W){1'b0}}, elapsed_ms};
        sum_sat    = sum_raw[ACCUM_W] ? ACCUM_MAX : sum_raw[ACCUM_W-1:0];
        fall_delta = rate_delta(cfg.fall_rate);
        rise_delta = rate_delta(cfg.rise_rate);
        nxt        = cur;
        do_step    = 1'b0;

        if ((cur.fade_word[WORD_W-1 -: LEVEL_W] != cfg.target_level) && active)
        begin
            if (sum_sat < TICK_MS)
            begin
                nxt.time_accum = sum_sat;
            end
            else
            begin
                nxt.time_accum = sum_sat - TICK_MS;
                do_step        = 1'b1;
            end
        end

        // downward move
        word_a    = cur.fade_word;
        down_diff = {1'b0, cur.fade_word} - {1'b0, fall_delta};
        if (do_step && (cur.fade_word[WORD_W-1 -: LEVEL_W] > cfg.target_level))
        begin
            if (cfg.fall_rate == JUMP_RATE)
                word_a = {cfg.target_level, cur.fade_word[WORD_W-LEVEL_W-1:0]};
            else
                word_a = down_diff[WORD_W] ? '0 : down_diff[WORD_W-1:0];
        end

        // upward move, also after a downward overshoot
        word_b = word_a;
        up_sum = {1'b0, word_a} + {1'b0, rise_delta};
        if (do_step && (word_a[WORD_W-1 -: LEVEL_W] < cfg.target_level))
        begin
            if (cfg.rise_rate == JUMP_RATE)
                word_b = {cfg.target_level, word_a[WORD_W-LEVEL_W-1:0]};
            else
                word_b = (up_sum[WORD_W] || (up_sum[WORD_W-1:0] == WORD_MAX)) ?
                         WORD_MAX : up_sum[WORD_W-1:0];
        end

        nxt.fade_word = word_b;
        level_changed = word_b[WORD_W-1 -: LEVEL_W] != cur.fade_word[WORD_W-1 -: LEVEL_W];
    end

endmodule

// ===== sim/lbsf_level_watch.sv =====
// watcher for the slew fader: tracks register writes, predicts each level beat and compares
module lbsf_level_watch
    import lbsf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [RATE_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [15:0]       m_tdata,
    output int                errors,
    output int                outstanding,
    output int                level_changes
);

    typedef struct packed {
        logic               level_changed;
        logic [LEVEL_W-1:0] level;
        logic               active;
    } level_beat_t;

    cfg_t         regs;
    fader_state_t fader;
    level_beat_t  level_q[$];

    function automatic level_beat_t advance_fader(input logic [DT_W-1:0] dt);
        int          sum;
        int          delta;
        int          word;
        logic [7:0]  old_top;
        logic        enabled;
        level_beat_t res;
        old_top = fader.fade_word[15:8];
        enabled = (regs.rise_rate != '0) || (regs.fall_rate != '0);
        word    = fader.fade_word;
        if (old_top != regs.target_level && enabled)
        begin
            sum = int'(fader.time_accum) + int'(dt);
            if (sum > int'(ACCUM_MAX))
                sum = int'(ACCUM_MAX);
            if (sum < int'(TICK_MS))
                fader.time_accum = ACCUM_W'(sum);
            else
            begin
                fader.time_accum = ACCUM_W'(sum - int'(TICK_MS));
                // move down first, then up, so an overshoot below is pulled back
                if (word[15:8] > regs.target_level)
                begin
                    if (regs.fall_rate == JUMP_RATE)
                        word = {regs.target_level, word[7:0]};
                    else
                    begin
                        delta = int'(TICK_MS) * int'(regs.fall_rate);
                        word  = (word > delta) ? word - delta : 0;
                    end
                end
                if (word[15:8] < regs.target_level)
                begin
                    if (regs.rise_rate == JUMP_RATE)
                        word = {regs.target_level, word[7:0]};
                    else
                    begin
                        delta = int'(TICK_MS) * int'(regs.rise_rate);
                        word  = (word < int'(WORD_MAX) - delta) ? word + delta : int'(WORD_MAX);
                    end
                end
            end
        end
        fader.fade_word     = word[15:0];
        res.level_changed   = (fader.fade_word[15:8] != old_top);
        res.level           = fader.fade_word[15:8];
        res.active          = enabled;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        level_beat_t want;
        level_beat_t got;
        if (!rst_n)
        begin
            regs          = '0;
            fader         = '0;
            level_q.delete();
            errors        = 0;
            outstanding   = 0;
            level_changes = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TARGET_LEVEL: regs.target_level = cfg_wdata;
                    REG_RISE_RATE:    regs.rise_rate    = cfg_wdata;
                    REG_FALL_RATE:    regs.fall_rate    = cfg_wdata;
                    default:          ;
                endcase
            end
            if (s_tvalid && s_tready)
                level_q.push_back(advance_fader(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got.level_changed = m_tdata[0];
                got.level         = m_tdata[8:1];
                got.active        = m_tdata[9];
                if (level_q.size() == 0)
                begin
                    $error("result beat with nothing expected, m_tdata=%h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = level_q.pop_front();
                    if (got.level_changed === 1'b1)
                        level_changes++;
                    if (got.level_changed !== want.level_changed)
                    begin
                        $error("level_changed: expected %0d, got %0d",
                               want.level_changed, got.level_changed);
                        errors++;
                    end
                    if (got.level !== want.level)
                    begin
                        $error("level: expected %0d, got %0d", want.level, got.level);
                        errors++;
                    end
                    if (got.active !== want.active)
                    begin
                        $error("active: expected %0d, got %0d", want.active, got.active);
                        errors++;
                    end
                end
            end
            outstanding = level_q.size();
        end
    end

endmodule

// ===== sim/led_brightness_slew_fader_top_test.sv =====
// testbench top for the slew fader: stimulus, register settings, timeout and verdict
module led_brightness_slew_fader_top_test;
    import lbsf_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED  = 2'd3;
    localparam int               CYCLE_LIMIT = 200000;
    localparam int               RANDOM_BEATS = 1700;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [RATE_W-1:0] cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;   // [7:0] elapsed_ms
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [15:0]       m_tdata;          // [0] level_changed, [8:1] level, [9] active

    int errors;
    int outstanding;
    int level_changes;
    int cycles      = 0;
    int beats_sent  = 0;
    int settings    = 0;
    bit quiet       = 1'b0;

    led_brightness_slew_fader_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    lbsf_level_watch watch (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .errors        (errors),
        .outstanding   (outstanding),
        .level_changes (level_changes)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("led_brightness_slew_fader_top_test: done, errors");
            $finish;
        end
    end

    // result side stalls
    always @(posedge clk)
    begin
        m_tready <= rst_n && (quiet || ($urandom_range(99) >= 6));
    end

    task automatic send_beat(input logic [7:0] dt);
        if (!quiet && $urandom_range(99) < 6)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= dt;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic reprogram(input logic [7:0] target, input logic [7:0] rise,
                             input logic [7:0] fall);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_UNUSED;
        cfg_wdata <= 8'($urandom_range(255));
        @(posedge clk);
        cfg_index <= REG_TARGET_LEVEL;
        cfg_wdata <= target;
        @(posedge clk);
        cfg_index <= REG_RISE_RATE;
        cfg_wdata <= rise;
        @(posedge clk);
        cfg_index <= REG_FALL_RATE;
        cfg_wdata <= fall;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [7:0] pick_rate();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return JUMP_RATE;
            2:       return 8'd1;
            3:       return JUMP_RATE - 8'd1;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] pick_target();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] pick_elapsed();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(95, 105));
            3, 4, 5: return 8'($urandom_range(40));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial
    begin : stimulus
        int random_sent;
        int run_len;
        random_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: rates zero, level already at target
        send_beat(8'd255);
        send_beat(8'd0);
        // off target but both rates zero
        reprogram(8'd200, 8'd0, 8'd0);
        send_beat(8'd255);
        // sub-tick accumulation, then a jump up
        reprogram(8'd200, JUMP_RATE, 8'd0);
        send_beat(8'd99);
        send_beat(8'd0);
        send_beat(8'd1);
        send_beat(8'd255);
        // jump down
        reprogram(8'd0, 8'd0, JUMP_RATE);
        send_beat(8'd100);
        // slowest rise with the accumulator pinned at its limit
        reprogram(8'd255, 8'd1, 8'd0);
        repeat (4) send_beat(8'd255);
        // fast rise into top saturation
        reprogram(8'd255, JUMP_RATE - 8'd1, 8'd0);
        repeat (3) send_beat(8'd100);
        // fall overshoots below target, rise pulls back
        reprogram(8'd150, 8'd10, JUMP_RATE - 8'd1);
        repeat (3) send_beat(8'd100);
        // fall into bottom saturation
        reprogram(8'd0, 8'd0, 8'd200);
        repeat (2) send_beat(8'd100);

        while (random_sent < RANDOM_BEATS)
        begin
            reprogram(pick_target(), pick_rate(), pick_rate());
            run_len = $urandom_range(20, 80);
            repeat (run_len)
            begin
                quiet = (random_sent >= 700 && random_sent < 1000);
                send_beat(pick_elapsed());
                random_sent++;
            end
        end
        quiet = 1'b0;
        settle();

        $display("covered %0d tick beats over %0d register settings, jumps and saturation included",
                 beats_sent, settings);
        $display("%0d level changes seen on the result side", level_changes);
        if (errors == 0)
            $display("led_brightness_slew_fader_top_test: done, clean");
        else
            $display("led_brightness_slew_fader_top_test: done, errors");
        $finish;
    end

endmodule
